FILE: rtl/isu_pkg.sv
// Shared widths, register indexes and result types for the Ising spin update block.
package isu_pkg;

  // Default lattice side and coordinate field width
  localparam int unsigned SIDE_DEF   = 256;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned COORD_VALS = 1 << COORD_W;

  // Field widths
  localparam int unsigned Q88_W      = 16;
  localparam int unsigned PROB_W     = 16;
  localparam int unsigned DE_W       = 20;
  localparam int unsigned MAG_W      = 18;
  localparam int unsigned ACC_N      = 10;
  localparam int unsigned ACC_IDX_W  = 4;
  localparam int unsigned NBR_W      = 3;

  // Stream word widths
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_MID  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_HIGH = 3'd4;

  // Register reset values
  localparam logic signed [Q88_W-1:0] COUPLING_RST = 16'sd256;
  localparam logic signed [Q88_W-1:0] FIELD_RST    = 16'sd0;

  // Decision of one flip attempt
  typedef struct packed {
    logic                   flip;
    logic signed [DE_W-1:0] de;
  } isu_flip_t;

endpackage

FILE: rtl/isu_row_ram.sv
// Lattice row memory: one write port, one read port with registered read data.
module isu_row_ram
  import isu_pkg::*;
#(
  parameter int unsigned DEPTH = SIDE_DEF,
  parameter int unsigned WIDTH = SIDE_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, old data on a same-cycle write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/isu_flip_unit.sv
// Energy change and Metropolis acceptance decision for one site.
module isu_flip_unit
  import isu_pkg::*;
(
  input  logic                    spin_up_i,
  input  logic [NBR_W-1:0]        nbr_up_i,
  input  logic signed [Q88_W-1:0] coupling_i,
  input  logic signed [Q88_W-1:0] field_i,
  input  logic [ACC_N*PROB_W-1:0] acc_tbl_i,
  input  logic [PROB_W-1:0]       uniform_i,
  output isu_flip_t               res_o
);

  logic signed [DE_W-1:0]  nsum;
  logic signed [DE_W-1:0]  cpl_x;
  logic signed [DE_W-1:0]  prod;
  logic signed [DE_W-1:0]  diff;
  logic signed [DE_W-1:0]  twice;
  logic signed [DE_W-1:0]  de_val;
  logic                    flip_val;
  logic [ACC_IDX_W-1:0]    k;
  logic [PROB_W-1:0]       prob_tbl [ACC_N];
  logic [PROB_W-1:0]       prob;

  // Neighbor sum n = 2*up_count - 4, then dE = 2*s*(J*n - h)
  always_comb begin
    nsum   = $signed({{(DE_W-NBR_W-1){1'b0}}, nbr_up_i, 1'b0}) - 20'sd4;
    cpl_x  = DE_W'(coupling_i);
    prod   = cpl_x * nsum;
    diff   = prod - DE_W'(field_i);
    twice  = diff <<< 1;
    de_val = spin_up_i ? twice : -twice;
  end

  // Unpack the acceptance table and pick entry 5*up + up_count
  always_comb begin
    for (int i = 0; i < ACC_N; i++) begin
      prob_tbl[i] = acc_tbl_i[PROB_W*i +: PROB_W];
    end
    k = spin_up_i ? (ACC_IDX_W'(nbr_up_i) + 4'd5) : ACC_IDX_W'(nbr_up_i);
    prob = prob_tbl[k];
    flip_val = de_val[DE_W-1] | (prob > uniform_i);
  end

  assign res_o = '{flip: flip_val, de: de_val};

endmodule

FILE: rtl/ising_metropolis_spin_update.sv
// Ising lattice Metropolis spin update: control, lattice memory and result register.
// An accepted word passes through states S_UP, S_DN and S_CALC, and its result word is then
// registered. A new word is taken only as the last one finishes, set by the three row reads
//   (row above, own row, row below) that share the single read port of the row memory.
// Reset: config registers take their reset values at once; a clearing pass then
//   writes every row to all +1, with s_axis_tready_o low.
module ising_metropolis_spin_update
  import isu_pkg::*;
#(
  parameter int unsigned SIDE = SIDE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave side: tdata = row[7:0], col[15:8], spin_value[16], uniform[32:17], zero pad
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser = mode
  input  logic                  s_axis_tuser_i,
  // master side: tdata = spin_now[0], flipped[1], delta_energy[21:2],
  //   magnetisation[39:22]
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(SIDE);
  localparam logic [CW-1:0] LAST = CW'(SIDE - 1);
  localparam logic [MAG_W-1:0] TOTAL_RST = MAG_W'((SIDE * SIDE) % (1 << MAG_W));

  typedef enum logic [1:0] {
    S_IDLE,
    S_UP,
    S_DN,
    S_CALC
  } state_e;

  state_e state_q, state_d;

  // Coordinate reduction modulo SIDE
  logic [CW-1:0] coord_mod [COORD_VALS];
  for (genvar g = 0; g < COORD_VALS; g++) begin : g_mod
    localparam int unsigned MODV = g % SIDE;
    assign coord_mod[g] = CW'(MODV);
  end

  // Config registers
  logic signed [Q88_W-1:0] coupling_q, field_q;
  logic [63:0]             acc_low_q, acc_mid_q;
  logic [31:0]             acc_high_q;

  // Clearing pass
  logic          clr_busy_q;
  logic [CW-1:0] clr_row_q;

  // Item payload
  logic                mode_q, spin_value_q;
  logic [CW-1:0]       r_q, c_q;
  logic [PROB_W-1:0]   uniform_q;
  logic [SIDE-1:0]     center_q;
  logic                up_bit_q;
  logic                fwd_q;
  logic [SIDE-1:0]     fwd_row_q;
  logic [MAG_W-1:0]    total_q, total_d;
  logic                m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;

  logic          accept, fin_ok, finish;
  logic [CW-1:0] row_in, col_in;
  logic [CW-1:0] r_up, r_dn, c_lf, c_rt;
  logic          re, we;
  logic [CW-1:0] raddr, waddr;
  logic [SIDE-1:0] rdata, wdata, wr_row;
  logic          s_c, new_spin, changed;
  logic [NBR_W-1:0] nbr_up;
  isu_flip_t     fres;
  logic signed [DE_W-1:0] de_out;

  // Handshakes
  assign fin_ok = !m_valid_q || m_axis_tready_i;
  assign finish = (state_q == S_CALC) && fin_ok;
  assign s_axis_tready_o = !clr_busy_q && ((state_q == S_IDLE) || finish);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o = 1'b1;

  assign row_in = coord_mod[s_axis_tdata_i[7:0]];
  assign col_in = coord_mod[s_axis_tdata_i[15:8]];

  // Wrapped neighbor coordinates
  assign r_up = (r_q == '0) ? LAST : r_q - CW'(1);
  assign r_dn = (r_q == LAST) ? '0 : r_q + CW'(1);
  assign c_lf = (c_q == '0) ? LAST : c_q - CW'(1);
  assign c_rt = (c_q == LAST) ? '0 : c_q + CW'(1);

  // Memory port control: own row on accept, then row above, then row below
  assign re    = accept || (state_q == S_UP) || (state_q == S_DN);
  assign raddr = (state_q == S_UP) ? r_up : (state_q == S_DN) ? r_dn : row_in;
  assign we    = clr_busy_q || finish;
  assign waddr = clr_busy_q ? clr_row_q : r_q;
  assign wdata = clr_busy_q ? '1 : wr_row;

  isu_row_ram #(
    .DEPTH (SIDE),
    .WIDTH (SIDE),
    .AW    (CW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Count up-neighbors: left, right, above, below
  assign s_c = center_q[c_q];
  assign nbr_up = NBR_W'(center_q[c_lf]) + NBR_W'(center_q[c_rt])
                + NBR_W'(up_bit_q) + NBR_W'(rdata[c_q]);

  isu_flip_unit u_flip (
    .spin_up_i  (s_c),
    .nbr_up_i   (nbr_up),
    .coupling_i (coupling_q),
    .field_i    (field_q),
    .acc_tbl_i  ({acc_high_q, acc_mid_q, acc_low_q}),
    .uniform_i  (uniform_q),
    .res_o      (fres)
  );

  // Resolve the new spin, running total and result word
  always_comb begin
    new_spin = mode_q ? (s_c ^ fres.flip) : spin_value_q;
    changed  = new_spin != s_c;
    de_out   = mode_q ? fres.de : '0;
    wr_row   = center_q;
    wr_row[c_q] = new_spin;
    total_d  = total_q;
    if (changed) begin
      total_d = new_spin ? total_q + MAG_W'(2) : total_q - MAG_W'(2);
    end
  end

  // Next state and output register
  always_comb begin
    state_d   = state_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_UP;
        end
      end
      S_UP:   state_d = S_DN;
      S_DN:   state_d = S_CALC;
      S_CALC: begin
        if (finish) begin
          state_d   = accept ? S_UP : S_IDLE;
          m_valid_d = 1'b1;
          m_data_d  = {total_d, de_out, mode_q & fres.flip, new_spin};
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State, clearing pass, totals, config and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      clr_busy_q <= 1'b1;
      clr_row_q  <= '0;
      fwd_q      <= 1'b0;
      total_q    <= TOTAL_RST;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      coupling_q <= COUPLING_RST;
      field_q    <= FIELD_RST;
      acc_low_q  <= '0;
      acc_mid_q  <= '0;
      acc_high_q <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      // advance the clearing pass one row a cycle
      if (clr_busy_q) begin
        clr_row_q <= clr_row_q + CW'(1);
        if (clr_row_q == LAST) begin
          clr_busy_q <= 1'b0;
        end
      end
      // forward the row written at the edge the same row is read again
      fwd_q <= finish && accept && (row_in == r_q);
      if (finish) begin
        total_q <= total_d;
      end
      // config writes
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_COUPLING: coupling_q <= cfg_data_i[Q88_W-1:0];
          CFG_FIELD:    field_q    <= cfg_data_i[Q88_W-1:0];
          CFG_ACC_LOW:  acc_low_q  <= cfg_data_i;
          CFG_ACC_MID:  acc_mid_q  <= cfg_data_i;
          CFG_ACC_HIGH: acc_high_q <= cfg_data_i[31:0];
          default: ;
        endcase
      end
    end
  end

  // Item payload and fetched rows
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q       <= s_axis_tuser_i;
      r_q          <= row_in;
      c_q          <= col_in;
      spin_value_q <= s_axis_tdata_i[16];
      uniform_q    <= s_axis_tdata_i[32:17];
    end
    if (finish) begin
      fwd_row_q <= wr_row;
    end
    if (state_q == S_UP) begin
      center_q <= fwd_q ? fwd_row_q : rdata;
    end
    if (state_q == S_DN) begin
      up_bit_q <= rdata[c_q];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef NO_ASSERTIONS
  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !clr_busy_q)
    else $error("input accepted during clearing pass");

  a_finish_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> m_axis_tvalid_o)
    else $error("finished item did not produce a result word");

  a_fwd_only_own_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> state_q == S_UP)
    else $error("row forwarding outside own-row fetch");

  a_total_moves_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(total_q) |-> $past(finish))
    else $error("magnetisation changed without a finished item");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready_i) |-> !finish)
    else $error("pending result word overwritten");
`endif

endmodule

FILE: tb/ising_metropolis_spin_update_test.sv
// Self-checking stream testbench for the Ising lattice Metropolis spin update block.
module ising_metropolis_spin_update_test;
  import isu_pkg::*;

  localparam int unsigned SIDE        = SIDE_DEF;
  localparam int unsigned SITES       = SIDE * SIDE;
  localparam int unsigned QUIET_LIMIT = 5000;

  // One result word, laid out as on m_axis_tdata_o (spin_now in bit 0)
  typedef struct packed {
    logic signed [MAG_W-1:0] magnetisation;
    logic signed [DE_W-1:0]  delta_energy;
    logic                    flipped;
    logic                    spin_now;
  } site_result_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  // row[7:0], col[15:8], spin_value[16], uniform[32:17], zero pad
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  // mode
  logic                  s_axis_tuser_i  = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // spin_now[0], flipped[1], delta_energy[21:2], magnetisation[39:22]
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;

  // Lattice and register shadow used for prediction
  bit                      spin_up [SITES];
  logic signed [MAG_W-1:0] spin_sum;
  logic signed [Q88_W-1:0] coupling_q88;
  logic signed [Q88_W-1:0] field_q88;
  logic [PROB_W-1:0]       accept_prob [ACC_N];

  site_result_t expected_sites [$];
  site_result_t want_site;
  site_result_t got_site;
  int           mismatches    = 0;
  int unsigned  quiet_cycles  = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  hold_cycles   = 0;

  ising_metropolis_spin_update dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Spin at a site as +1 / -1
  function automatic int spin_of(int unsigned r, int unsigned c);
    return spin_up[r * SIDE + c] ? 1 : -1;
  endfunction

  // Store a spin and track the running magnetisation
  function automatic void set_spin(int unsigned here, bit up);
    if (spin_up[here] != up) begin
      spin_sum      = up ? spin_sum + 18'sd2 : spin_sum - 18'sd2;
      spin_up[here] = up;
    end
  endfunction

  // Apply one word to the lattice shadow and return the result it should give
  function automatic site_result_t predict_site_update(logic mode, logic [COORD_W-1:0] row,
      logic [COORD_W-1:0] col, logic spin_in, logic [PROB_W-1:0] uniform);
    int unsigned  r;
    int unsigned  c;
    int unsigned  here;
    int unsigned  k;
    int           s;
    int           nsum;
    int           de;
    site_result_t res;
    r    = row % SIDE;
    c    = col % SIDE;
    here = r * SIDE + c;
    de   = 0;
    res.flipped = 1'b0;
    if (mode == 1'b0) begin
      set_spin(here, spin_in);
    end else begin
      s    = spin_up[here] ? 1 : -1;
      nsum = spin_of((r + 1) % SIDE, c) + spin_of((r + SIDE - 1) % SIDE, c)
           + spin_of(r, (c + 1) % SIDE) + spin_of(r, (c + SIDE - 1) % SIDE);
      k    = 5 * int'(spin_up[here]) + (nsum + 4) / 2;
      de   = 2 * s * (int'(coupling_q88) * nsum - int'(field_q88));
      if (de < 0 || accept_prob[k] > uniform) begin
        res.flipped = 1'b1;
        set_spin(here, !spin_up[here]);
      end
    end
    res.spin_now      = spin_up[here];
    res.delta_energy  = de[DE_W-1:0];
    res.magnetisation = spin_sum;
    return res;
  endfunction

  // Offer one word, idling at random first, and record its expected result
  task automatic send_site(logic mode, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
      logic spin_in, logic [PROB_W-1:0] uniform);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = mode;
    s_axis_tdata_i  = IN_DATA_W'({uniform, spin_in, col, row});
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_sites.push_back(predict_site_update(mode, row, col, spin_in, uniform));
  endtask

  // Drop valid and let every outstanding result drain
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (expected_sites.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write one register; called at a falling edge, returns at a falling edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_COUPLING: coupling_q88 = value[Q88_W-1:0];
      CFG_FIELD:    field_q88    = value[Q88_W-1:0];
      CFG_ACC_LOW:  for (int i = 0; i < 4; i++) accept_prob[i] = value[PROB_W*i +: PROB_W];
      CFG_ACC_MID:  for (int i = 0; i < 4; i++) accept_prob[4+i] = value[PROB_W*i +: PROB_W];
      CFG_ACC_HIGH: for (int i = 0; i < 2; i++) accept_prob[8+i] = value[PROB_W*i +: PROB_W];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Reprogram every register once the block is idle
  task automatic program_lattice_regs(logic [Q88_W-1:0] j, logic [Q88_W-1:0] h,
      logic [63:0] lo, logic [63:0] mid, logic [63:0] hi);
    wait_drained();
    write_reg(CFG_COUPLING, {$urandom, 16'($urandom), j});
    write_reg(CFG_FIELD, {$urandom, 16'($urandom), h});
    write_reg(CFG_ACC_LOW, lo);
    write_reg(CFG_ACC_MID, mid);
    write_reg(CFG_ACC_HIGH, hi);
    cfg_valid_i = 1'b0;
  endtask

  // Mostly sites in a small patch across the wrap corner, some anywhere
  task automatic run_random_sites(int unsigned count);
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(4) != 0) begin
        row = COORD_W'(254 + $urandom_range(7));
        col = COORD_W'(254 + $urandom_range(7));
      end else begin
        row = COORD_W'($urandom);
        col = COORD_W'($urandom);
      end
      send_site($urandom_range(9) >= 3, row, col, 1'($urandom), 16'($urandom));
    end
  endtask

  // Reset values: unit coupling, no field, empty table
  task automatic test_default_lattice();
    send_site(1'b1, 8'd0, 8'd0, 1'b0, 16'h0000);
    send_site(1'b0, 8'd0, 8'd0, 1'b0, 16'hFFFF);
    send_site(1'b0, 8'd0, 8'd0, 1'b0, 16'h0000);
    send_site(1'b1, 8'd0, 8'd1, 1'b1, 16'h0000);
    send_site(1'b1, 8'd0, 8'd0, 1'b1, 16'hFFFF);
    send_site(1'b0, 8'd255, 8'd255, 1'b0, 16'h0000);
    send_site(1'b1, 8'd0, 8'd255, 1'b0, 16'h0000);
    send_site(1'b1, 8'd255, 8'd0, 1'b0, 16'h0000);
    send_site(1'b1, 8'd255, 8'd255, 1'b1, 16'h0000);
    send_site(1'b0, 8'd255, 8'd255, 1'b1, 16'h0000);
  endtask

  // Largest energy changes of either sign
  task automatic test_energy_extremes();
    program_lattice_regs(16'h8000, 16'h7FFF, '0, '0, '0);
    send_site(1'b1, 8'd10, 8'd10, 1'b0, 16'hFFFF);
    send_site(1'b1, 8'd10, 8'd10, 1'b0, 16'h0000);
    send_site(1'b0, 8'd10, 8'd10, 1'b1, 16'h0000);
    program_lattice_regs(16'h7FFF, 16'h8000, '0, '0, '0);
    send_site(1'b1, 8'd20, 8'd20, 1'b1, 16'h0000);
    send_site(1'b0, 8'd21, 8'd20, 1'b0, 16'h0000);
    send_site(1'b1, 8'd20, 8'd20, 1'b0, 16'h0000);
  endtask

  // Zero energy change: the table alone decides, strictly greater wins
  task automatic test_zero_energy();
    program_lattice_regs(16'h0000, 16'h0000, '1, '1, '1);
    send_site(1'b1, 8'd30, 8'd30, 1'b0, 16'hFFFF);
    send_site(1'b1, 8'd30, 8'd30, 1'b0, 16'hFFFE);
    send_site(1'b1, 8'd30, 8'd30, 1'b0, 16'hFFFF);
    send_site(1'b1, 8'd30, 8'd30, 1'b0, 16'h0000);
    program_lattice_regs(16'h0000, 16'h0000, '0, '0, '0);
    send_site(1'b1, 8'd30, 8'd30, 1'b0, 16'h0000);
  endtask

  // Random words under each idling pattern, random and extreme settings
  task automatic test_random_phases();
    int unsigned send_pct [3] = '{34, 71, 0};
    int unsigned recv_pct [3] = '{71, 34, 0};
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      program_lattice_regs(16'($urandom_range(2048)) - 16'd1024,
                           16'($urandom_range(512)) - 16'd256,
                           {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      run_random_sites(150);
      case (p)
        0: program_lattice_regs(16'h8000, 16'h7FFF, '1, '0, {$urandom, $urandom});
        1: program_lattice_regs(16'h7FFF, 16'h8000, '0, '1, '1);
        default: program_lattice_regs(16'h0000, 16'h0000, {$urandom, $urandom},
                                      {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      run_random_sites(150);
    end
  endtask

  // Hold the output off long enough that the input stalls
  task automatic test_backpressure();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 200;
    run_random_sites(24);
  endtask

  // Drive ready: long hold first, else random stalls
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      m_axis_tready_i = 1'b0;
      hold_cycles     = hold_cycles - 1;
    end else begin
      m_axis_tready_i = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_sites.size() == 0) begin
        $error("unexpected result word %h", m_axis_tdata_o);
        mismatches++;
      end else begin
        want_site = expected_sites.pop_front();
        got_site  = m_axis_tdata_o;
        if (got_site.spin_now !== want_site.spin_now) begin
          $error("spin_now expected %0d actual %0d", want_site.spin_now, got_site.spin_now);
          mismatches++;
        end
        if (got_site.flipped !== want_site.flipped) begin
          $error("flipped expected %0d actual %0d", want_site.flipped, got_site.flipped);
          mismatches++;
        end
        if (got_site.delta_energy !== want_site.delta_energy) begin
          $error("delta_energy expected %0d actual %0d",
                 want_site.delta_energy, got_site.delta_energy);
          mismatches++;
        end
        if (got_site.magnetisation !== want_site.magnetisation) begin
          $error("magnetisation expected %0d actual %0d",
                 want_site.magnetisation, got_site.magnetisation);
          mismatches++;
        end
      end
    end
  end

  // Abort when no word moves on any channel for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ising_metropolis_spin_update: mismatch");
      $finish;
    end
  end

  initial begin
    foreach (spin_up[i]) spin_up[i] = 1'b1;
    spin_sum     = MAG_W'(SITES);
    coupling_q88 = COUPLING_RST;
    field_q88    = FIELD_RST;
    foreach (accept_prob[i]) accept_prob[i] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    test_default_lattice();
    test_energy_extremes();
    test_zero_energy();
    test_random_phases();
    test_backpressure();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ising_metropolis_spin_update: match");
    end else begin
      $display("ising_metropolis_spin_update: mismatch");
    end
    $finish;
  end

endmodule
